>>> rtl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: keyword classifier constants
// Keyword byte table, token class codes and character constants.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int NUM_KW    = 61;
    localparam int KW_BYTES  = 28;
    localparam int KW_LEN_W  = $clog2(KW_BYTES + 1);
    localparam int MAX_LEN   = 32;
    localparam int POS_W     = 6;
    localparam int CLASS_W   = 7;

    typedef logic [KW_BYTES-1:0][7:0] t_kw_text;
    typedef logic [KW_LEN_W-1:0]      t_kw_len;
    typedef logic [CLASS_W-1:0]       t_class;

    localparam t_class CLS_DIRECTIVE  = 7'd61;
    localparam t_class CLS_INTEGER    = 7'd62;
    localparam t_class CLS_DOUBLE     = 7'd63;
    localparam t_class CLS_STRING     = 7'd64;
    localparam t_class CLS_CHAR       = 7'd65;
    localparam t_class CLS_IDENTIFIER = 7'd66;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Cyrillic lower-case letters in UTF-8
    localparam logic [15:0] C_A    = 16'hD0B0;
    localparam logic [15:0] C_B    = 16'hD0B1;
    localparam logic [15:0] C_V    = 16'hD0B2;
    localparam logic [15:0] C_G    = 16'hD0B3;
    localparam logic [15:0] C_D    = 16'hD0B4;
    localparam logic [15:0] C_E    = 16'hD0B5;
    localparam logic [15:0] C_ZH   = 16'hD0B6;
    localparam logic [15:0] C_I    = 16'hD0B8;
    localparam logic [15:0] C_IK   = 16'hD0B9;
    localparam logic [15:0] C_K    = 16'hD0BA;
    localparam logic [15:0] C_L    = 16'hD0BB;
    localparam logic [15:0] C_M    = 16'hD0BC;
    localparam logic [15:0] C_N    = 16'hD0BD;
    localparam logic [15:0] C_O    = 16'hD0BE;
    localparam logic [15:0] C_P    = 16'hD0BF;
    localparam logic [15:0] C_R    = 16'hD180;
    localparam logic [15:0] C_S    = 16'hD181;
    localparam logic [15:0] C_T    = 16'hD182;
    localparam logic [15:0] C_U    = 16'hD183;
    localparam logic [15:0] C_TS   = 16'hD186;
    localparam logic [15:0] C_CH   = 16'hD187;
    localparam logic [15:0] C_Y    = 16'hD18B;
    localparam logic [15:0] C_SOFT = 16'hD18C;
    localparam logic [15:0] C_YU   = 16'hD18E;
    localparam logic [15:0] C_YA   = 16'hD18F;

    // Keyword text, right-justified: the last byte sits in entry 0, the
    // unused upper entries are zero.
    localparam t_kw_text KW_TEXT [NUM_KW] = '{
        t_kw_text'({C_P, C_O, C_S, C_T, C_O, C_YA, C_N, C_N, C_O}),
        t_kw_text'({C_TS, C_E, C_L, C_Y, C_IK}),
        t_kw_text'({C_D, C_V, C_O, C_IK, C_N, C_O, C_IK}),
        t_kw_text'({C_B, C_U, C_L, C_SOFT}),
        t_kw_text'({C_P, C_U, C_S, C_T, C_O, C_T, C_A}),
        t_kw_text'({C_S, C_I, C_M, C_V, C_O, C_L}),
        t_kw_text'({C_S, C_T, C_R, C_O, C_K, C_A}),
        t_kw_text'({C_A, C_V, C_T, C_O, C_M, C_A, C_T, C_I, C_CH, C_E, C_S, C_K,
                    C_I, C_IK}),
        t_kw_text'({C_TS, C_I, C_K, C_L}),
        t_kw_text'({C_P, C_O, C_K, C_A}),
        t_kw_text'({C_D, C_E, C_L, C_A, C_IK}),
        t_kw_text'({C_P, C_R, C_E, C_R, C_V, C_A, C_T, C_SOFT}),
        t_kw_text'({C_P, C_R, C_O, C_D, C_O, C_L, C_ZH, C_I, C_T, C_SOFT}),
        t_kw_text'({C_E, C_S, C_L, C_I}),
        t_kw_text'({C_T, C_O, C_G, C_D, C_A}),
        t_kw_text'(">"),  t_kw_text'("<"),  t_kw_text'("<="), t_kw_text'(">="),
        t_kw_text'("=="), t_kw_text'("!="), t_kw_text'("&&"), t_kw_text'("||"),
        t_kw_text'("!"),
        t_kw_text'("+"),  t_kw_text'("-"),  t_kw_text'("*"),  t_kw_text'("/"),
        t_kw_text'("++"), t_kw_text'("--"), t_kw_text'("^"),
        t_kw_text'("{"),  t_kw_text'("}"),  t_kw_text'("("),  t_kw_text'(")"),
        t_kw_text'("["),  t_kw_text'("]"),
        t_kw_text'("="),  t_kw_text'("+="), t_kw_text'("-="), t_kw_text'("*="),
        t_kw_text'("/="),
        t_kw_text'({C_V, C_E, C_R, C_N, C_I}),
        t_kw_text'({C_P, C_R, C_O, C_TS, C_E, C_D, C_U, C_R, C_A}),
        t_kw_text'({C_P, C_A, C_M, C_YA, C_T, C_SOFT}),
        t_kw_text'({C_U, C_D, C_A, C_L, C_I, C_T, C_SOFT}),
        t_kw_text'({C_I, C_S, C_T, C_I, C_N, C_A}),
        t_kw_text'({C_L, C_O, C_ZH, C_SOFT}),
        t_kw_text'({C_P, C_E, C_R, C_E, C_K, C_L, C_YU, C_CH, C_A, C_T, C_E, C_L,
                    C_SOFT}),
        t_kw_text'({C_V, C_Y, C_B, C_O, C_R}),
        t_kw_text'({C_P, C_O, CH_SPACE, C_U, C_M, C_O, C_L, C_CH, C_A, C_N, C_I,
                    C_YU}),
        t_kw_text'(";"),  t_kw_text'(":"),  t_kw_text'(","),  t_kw_text'("."),
        t_kw_text'("?"),  t_kw_text'("::"), t_kw_text'("&"),
        t_kw_text'("//"), t_kw_text'("/*"), t_kw_text'("*/")
    };

    // Keyword bytes are never zero, so the length is the count of
    // nonzero entries. Elaboration-time only.
    function automatic t_kw_len kw_len(input t_kw_text t);
        t_kw_len n;
        n = '0;
        for (int i = 0; i < KW_BYTES; i++) begin
            if (t[i] != 8'h00) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/lexeme_keyword_classifier.sv
// ----------------------------------------------------------------------------
// lexeme_keyword_classifier
// Classifies one UTF-8 lexeme, streamed a byte per transaction, into a
// keyword, directive, integer, double, string, char or identifier class.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser | tlast
//  s_axis  | in  | [7:0] lexeme_byte     | -     | final_byte
//  m_axis  | out | [6:0] token_class, 0  | -     | -
//
//  One byte per cycle while o_s_axis_tready is high; a lexeme gives its
//  class in the cycle after its final byte, from the result register.
//  Every keyword compares its byte at the current position in parallel;
//  the candidate mask and the digit/dot flags carry state between bytes.
//  Reset (i_rst_n low, synchronous) clears the candidate mask, position, digit/dot flags and the result valid flag.
//  o_s_axis_tready drops only while a result waits and m_axis is stalled.
// ----------------------------------------------------------------------------
module lexeme_keyword_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] lexeme_byte
    input  logic       i_s_axis_tlast,   // final_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [6:0] token_class, [7] zero
);
    import lkc_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [NUM_KW-1:0] r_cand;
    logic [POS_W-1:0]  r_pos;
    logic              r_all_digits;
    logic              r_double_valid;
    logic              r_dot_seen;
    logic [7:0]        r_first;
    logic              r_out_valid;
    t_class            r_out_class;

    logic [NUM_KW-1:0] n_cand;
    logic              n_all_digits;
    logic              n_double_valid;
    logic              n_dot_seen;
    logic [7:0]        n_first;
    t_class            n_class;

    logic [NUM_KW-1:0] w_match;
    t_class            w_kw_class;
    logic              w_accept;
    logic              w_digit;
    logic              w_dot;
    logic [7:0]        w_byte;

    assign w_byte          = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_class};

    // Per-keyword byte compare at the current position
    for (genvar k = 0; k < NUM_KW; k++) begin : g_kw
        localparam t_kw_len LEN = kw_len(KW_TEXT[k]);
        logic [KW_LEN_W-1:0] w_idx;
        logic                w_hit;

        // Text is right-justified, so position p sits at entry LEN-1-p
        assign w_idx = KW_LEN_W'(LEN - 1'b1) - r_pos[KW_LEN_W-1:0];
        assign w_hit = (r_pos < POS_W'(LEN)) && (r_pos < POS_W'(MAX_LEN))
                       && (KW_TEXT[k][w_idx] == w_byte);
        assign n_cand[k]  = r_cand[k] && w_hit;
        assign w_match[k] = n_cand[k] && ((7'(r_pos) + 7'd1) == 7'(LEN));
    end

    // Keywords are distinct, so at most one matches: OR the indices
    always_comb begin
        w_kw_class = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (w_match[k]) begin
                w_kw_class = w_kw_class | CLASS_W'(k);
            end
        end
    end

    assign w_digit        = (w_byte >= CH_0) && (w_byte <= CH_9);
    assign w_dot          = (w_byte == CH_DOT);
    assign n_all_digits   = r_all_digits && w_digit;
    assign n_dot_seen     = r_dot_seen || w_dot;
    assign n_double_valid = r_double_valid && (w_dot ? !r_dot_seen : w_digit);
    assign n_first        = (r_pos == '0) ? w_byte : r_first;

    always_comb begin
        priority if (w_match != '0) begin
            n_class = w_kw_class;
        end else if (n_first == CH_HASH) begin
            n_class = CLS_DIRECTIVE;
        end else if (n_all_digits) begin
            n_class = CLS_INTEGER;
        end else if (n_double_valid) begin
            n_class = CLS_DOUBLE;
        end else if (n_first == CH_DQUOTE && w_byte == CH_DQUOTE) begin
            n_class = CLS_STRING;
        end else if (n_first == CH_APOS && w_byte == CH_APOS) begin
            n_class = CLS_CHAR;
        end else begin
            n_class = CLS_IDENTIFIER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand         <= '1;
            r_pos          <= '0;
            r_all_digits   <= 1'b1;
            r_double_valid <= 1'b1;
            r_dot_seen     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept && i_s_axis_tlast) begin
                // lexeme done: restart the scan
                r_cand         <= '1;
                r_pos          <= '0;
                r_all_digits   <= 1'b1;
                r_double_valid <= 1'b1;
                r_dot_seen     <= 1'b0;
            end else if (w_accept) begin
                r_cand         <= n_cand;
                r_pos          <= (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
                r_all_digits   <= n_all_digits;
                r_double_valid <= n_double_valid;
                r_dot_seen     <= n_dot_seen;
            end
            if (w_accept && i_s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= n_first;
        end
        if (w_accept && i_s_axis_tlast) begin
            r_out_class <= n_class;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tlast) |=> (r_pos == '0 && r_cand == '1))
        else $error("lexeme state not cleared after final byte");

    a_one_kw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> $onehot0(w_match))
        else $error("more than one keyword matched");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= 8'(CLS_IDENTIFIER)))
        else $error("token class out of range");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept && i_s_axis_tlast))
        else $error("result without a final byte");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all_digits |-> (r_double_valid && !r_dot_seen))
        else $error("digit and dot flags inconsistent");

endmodule

>>> bench/tb_lexeme_keyword_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lexeme_keyword_classifier: self-checking bench for the lexeme classifier
// Streams lexemes a byte per transaction and checks each token class against
// the directed table's class or, where it has none, a byte-serial class
// predictor. A short directed table comes first, then random lexemes, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_lexeme_keyword_classifier;
    import lkc_pkg::*;

    localparam int ITEMS     = 1200;
    localparam int CALM_AT   = 1000;
    localparam int N_DIR     = 25;
    localparam int USE_MODEL = -1;
    localparam int DRAIN     = 8;

    // keyword indexes used by the directed table
    localparam int KW_POSTOYANNO  = 0;
    localparam int KW_AUTO        = 7;
    localparam int KW_GREATER     = 15;
    localparam int KW_DEFAULT     = 50;
    localparam int KW_DOT         = 54;
    localparam int KW_SCOPE       = 56;
    localparam int KW_SLASH_STAR  = 59;
    localparam int KW_COMMENT_END = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;  // [7:0] lexeme_byte
    logic       i_s_axis_tlast = 1'b0;   // final_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [6:0] token_class, [7] zero

    lexeme_keyword_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Keyword spelling: upper-case ASCII letters stand for Cyrillic letters
    // (A B V G D E J=zh I Y=short i K L M N O P R S T U C=ts H=ch W=yery
    // X=soft sign Q=yu Z=ya), everything else is a literal byte.
    string kw_src [NUM_KW] = '{
        "POSTOZNNO", "CELWY", "DVOYNOY", "BULX", "PUSTOTA", "SIMVOL", "STROKA",
        "AVTOMATIHESKIY", "CIKL", "POKA", "DELAY", "PRERVATX", "PRODOLJITX",
        "ESLI", "TOGDA",
        ">", "<", "<=", ">=", "==", "!=", "&&", "||", "!",
        "+", "-", "*", "/", "++", "--", "^",
        "{", "}", "(", ")", "[", "]",
        "=", "+=", "-=", "*=", "/=",
        "VERNI", "PROCEDURA", "PAMZTX", "UDALITX", "ISTINA", "LOJX",
        "PEREKLQHATELX", "VWBOR", "PO UMOLHANIQ",
        ";", ":", ",", ".", "?", "::", "&",
        "//", "/*", "*/"
    };

    // Directed table; '@' in a row stands for a zero byte.
    string dir_text [N_DIR] = '{
        "POSTOZNNO", "PO UMOLHANIQ", "AVTOMATIHESKIY", "AVTOMATIHESKIYA",
        ">", ".", "::", "/*", "*/",
        "#include", "#", "#123",
        "0", "9876543210", "3.14", "1.", "..", "1.2.3",
        "\"", "\"a b\"", "'", "'x'",
        "1234567890123456789012345678901234567890",
        "POSTOZNNOPOSTOZNNOPOSTOZNNOPOSTOZNNO",
        "@\377x"
    };
    int dir_cls [N_DIR] = '{
        KW_POSTOYANNO, KW_DEFAULT, KW_AUTO, CLS_IDENTIFIER,
        KW_GREATER, KW_DOT, KW_SCOPE, KW_SLASH_STAR, KW_COMMENT_END,
        CLS_DIRECTIVE, CLS_DIRECTIVE, CLS_DIRECTIVE,
        CLS_INTEGER, CLS_INTEGER, CLS_DOUBLE, CLS_DOUBLE, CLS_IDENTIFIER, USE_MODEL,
        CLS_STRING, CLS_STRING, CLS_CHAR, CLS_CHAR,
        CLS_INTEGER,
        USE_MODEL,
        USE_MODEL
    };

    logic [7:0] kw_byte [NUM_KW][64];
    int         kw_size [NUM_KW];

    // class predictor state
    logic [NUM_KW-1:0] kw_alive;
    logic [5:0]        lex_pos;
    bit                digits_only;
    bit                number_ok;
    bit                dot_found;
    logic [7:0]        lead_byte;

    logic [7:0] lex_buf [$];
    t_class     class_q [$];
    int         override_q [$];
    int         errors = 0;
    int         bytes_sent = 0;
    bit         calm = 1'b0;
    t_class     exp_cls;
    int         forced;

    function automatic void put_text(input string s);
        logic [15:0] u;
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "A": u = 16'hD0B0;  "B": u = 16'hD0B1;  "V": u = 16'hD0B2;
                "G": u = 16'hD0B3;  "D": u = 16'hD0B4;  "E": u = 16'hD0B5;
                "J": u = 16'hD0B6;  "I": u = 16'hD0B8;  "Y": u = 16'hD0B9;
                "K": u = 16'hD0BA;  "L": u = 16'hD0BB;  "M": u = 16'hD0BC;
                "N": u = 16'hD0BD;  "O": u = 16'hD0BE;  "P": u = 16'hD0BF;
                "R": u = 16'hD180;  "S": u = 16'hD181;  "T": u = 16'hD182;
                "U": u = 16'hD183;  "C": u = 16'hD186;  "H": u = 16'hD187;
                "W": u = 16'hD18B;  "X": u = 16'hD18C;  "Q": u = 16'hD18E;
                "Z": u = 16'hD18F;
                default: u = 16'h0000;
            endcase
            if (u != 16'h0000) begin
                lex_buf.push_back(u[15:8]);
                lex_buf.push_back(u[7:0]);
            end else if (s[i] == "@") begin
                lex_buf.push_back(8'h00);
            end else begin
                lex_buf.push_back(s[i]);
            end
        end
    endfunction

    function automatic void clear_lexeme();
        kw_alive    = '1;
        lex_pos     = '0;
        digits_only = 1'b1;
        number_ok   = 1'b1;
        dot_found   = 1'b0;
        lead_byte   = 8'h00;
    endfunction

    // Advance the predictor by one byte; on the final byte queue the class.
    function automatic void classify_byte(input logic [7:0] b, input bit last,
                                          input int override);
        bit digit;
        bit found;
        int cls;
        digit = (b >= CH_0) && (b <= CH_9);
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw_alive[k] && (lex_pos >= MAX_LEN || lex_pos >= kw_size[k] ||
                                kw_byte[k][lex_pos] != b)) begin
                kw_alive[k] = 1'b0;
            end
        end
        if (lex_pos == 0) begin
            lead_byte = b;
        end
        if (!digit) begin
            digits_only = 1'b0;
        end
        if (b == CH_DOT) begin
            if (dot_found) begin
                number_ok = 1'b0;
            end
            dot_found = 1'b1;
        end else if (!digit) begin
            number_ok = 1'b0;
        end
        if (!last) begin
            if (lex_pos != 6'd63) begin
                lex_pos = lex_pos + 6'd1;
            end
            return;
        end
        found = 1'b0;
        cls   = CLS_IDENTIFIER;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!found && kw_alive[k] && kw_size[k] == int'(lex_pos) + 1) begin
                cls   = k;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (lead_byte == CH_HASH) begin
                cls = CLS_DIRECTIVE;
            end else if (digits_only) begin
                cls = CLS_INTEGER;
            end else if (number_ok) begin
                cls = CLS_DOUBLE;
            end else if (lead_byte == CH_DQUOTE && b == CH_DQUOTE) begin
                cls = CLS_STRING;
            end else if (lead_byte == CH_APOS && b == CH_APOS) begin
                cls = CLS_CHAR;
            end
        end
        class_q.push_back(t_class'((override == USE_MODEL) ? cls : override));
        clear_lexeme();
    endfunction

    // Send lex_buf, one transaction per byte, with random gaps before bytes.
    task automatic send_lexeme();
        for (int i = 0; i < lex_buf.size(); i++) begin
            calm = (bytes_sent >= CALM_AT);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_s_axis_tvalid = 1'b1;
            i_s_axis_tdata  = lex_buf[i];
            i_s_axis_tlast  = (i == lex_buf.size() - 1);
            do @(posedge i_clk); while (!o_s_axis_tready);
            bytes_sent++;
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check the output first: it belongs to an older lexeme
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (class_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: got tdata=%h", o_m_axis_tdata);
                    end
                end else begin
                    exp_cls = class_q.pop_front();
                    if (o_m_axis_tdata !== {1'b0, exp_cls}) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("class mismatch: expected %0d, got tdata=%h",
                                     exp_cls, o_m_axis_tdata);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                forced = USE_MODEL;
                if (i_s_axis_tlast) begin
                    forced = override_q.pop_front();
                end
                classify_byte(i_s_axis_tdata, i_s_axis_tlast, forced);
            end
        end
    end

    // result side backpressure
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_lexeme_keyword_classifier: FAIL");
        $finish;
    end

    initial begin
        int         kind;
        int         n;
        int         idx;
        logic [7:0] bv;

        clear_lexeme();
        for (int k = 0; k < NUM_KW; k++) begin
            lex_buf.delete();
            put_text(kw_src[k]);
            kw_size[k] = lex_buf.size();
            for (int j = 0; j < 64; j++) begin
                kw_byte[k][j] = (j < lex_buf.size()) ? lex_buf[j] : 8'h00;
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            lex_buf.delete();
            put_text(dir_text[r]);
            override_q.push_back(dir_cls[r]);
            send_lexeme();
        end

        while (bytes_sent < ITEMS) begin
            lex_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                put_text(kw_src[$urandom_range(0, NUM_KW - 1)]);
            end else if (kind < 30) begin
                // near miss: shorten, extend or corrupt a keyword
                put_text(kw_src[$urandom_range(0, NUM_KW - 1)]);
                case ($urandom_range(0, 2))
                    0: begin
                        if (lex_buf.size() > 1) begin
                            void'(lex_buf.pop_back());
                        end else begin
                            bv = 8'($urandom_range(0, 255));
                            lex_buf.push_back(bv);
                        end
                    end
                    1: begin
                        bv = 8'($urandom_range(0, 255));
                        lex_buf.push_back(bv);
                    end
                    default: begin
                        idx = $urandom_range(0, lex_buf.size() - 1);
                        lex_buf[idx] = 8'($urandom_range(0, 255));
                    end
                endcase
            end else if (kind < 38) begin
                lex_buf.push_back(CH_HASH);
                repeat ($urandom_range(0, 10)) begin
                    bv = 8'($urandom_range(33, 126));
                    lex_buf.push_back(bv);
                end
            end else if (kind < 50) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 45)
                                                : $urandom_range(1, 12);
                repeat (n) begin
                    bv = CH_0 + 8'($urandom_range(0, 9));
                    lex_buf.push_back(bv);
                end
            end else if (kind < 62) begin
                repeat ($urandom_range(0, 6)) begin
                    bv = CH_0 + 8'($urandom_range(0, 9));
                    lex_buf.push_back(bv);
                end
                lex_buf.push_back(CH_DOT);
                repeat ($urandom_range(0, 6)) begin
                    bv = CH_0 + 8'($urandom_range(0, 9));
                    lex_buf.push_back(bv);
                end
                if ($urandom_range(0, 4) == 0) begin
                    lex_buf.push_back(CH_DOT);
                    bv = CH_0 + 8'($urandom_range(0, 9));
                    lex_buf.push_back(bv);
                end
            end else if (kind < 70) begin
                lex_buf.push_back(CH_DQUOTE);
                if ($urandom_range(0, 7) != 0) begin
                    repeat ($urandom_range(0, 10)) begin
                        bv = 8'($urandom_range(32, 126));
                        lex_buf.push_back(bv);
                    end
                    lex_buf.push_back(CH_DQUOTE);
                end
            end else if (kind < 78) begin
                lex_buf.push_back(CH_APOS);
                if ($urandom_range(0, 7) != 0) begin
                    repeat ($urandom_range(0, 3)) begin
                        bv = 8'($urandom_range(32, 126));
                        lex_buf.push_back(bv);
                    end
                    lex_buf.push_back(CH_APOS);
                end
            end else if (kind < 90) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70)
                                                : $urandom_range(1, 10);
                repeat (n) begin
                    bv = 8'($urandom_range(0, 255));
                    lex_buf.push_back(bv);
                end
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    bv = 8'($urandom_range(65, 122));
                    lex_buf.push_back(bv);
                end
            end
            override_q.push_back(USE_MODEL);
            send_lexeme();
        end
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;

        while (class_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_lexeme_keyword_classifier: PASS");
        end else begin
            $display("tb_lexeme_keyword_classifier: FAIL");
        end
        $finish;
    end

endmodule
